>>> sv/ebf_pkg.sv
// Shared types and constants for the enclosing bracket finder.
// Used by ebf_ctrl, ebf_dpath and enclosing_bracket_finder; no dependencies.
package ebf_pkg;

    // Buffer geometry: addresses follow the 6-bit query position field.
    localparam int STORE_DEPTH = 64;
    localparam int MAX_TEXT    = 64;
    localparam int ADDR_W      = 6;
    localparam int LEN_W       = 7;
    localparam int BYTE_W      = 8;
    localparam int CMD_W       = 2;

    // Request codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // Characters of interest.
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h29;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACK,
        ST_FWD,
        ST_EMIT,
        ST_RESP
    } t_state;

    typedef enum logic [1:0] {
        MODE_BACK,
        MODE_FWD,
        MODE_EMIT
    } t_mode;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear;
        logic append;
        logic load_back;
        logic load_fwd;
        logic load_emit;
        logic emit_whole;
        logic scan;
        logic put_empty;
    } t_ctl;

    // Datapath to controller status.
    typedef struct packed {
        logic query_bad;
        logic found;
        logic scan_end;
        logic open_ok;
    } t_sts;

endpackage

>>> sv/ebf_ctrl.sv
// Sequencer for the enclosing bracket finder: backward scan, forward scan, emit.
// Depends on ebf_pkg; drives ebf_dpath through t_ctl and reads t_sts.
module ebf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ebf_pkg::CMD_W-1:0] i_cmd,
    input  ebf_pkg::t_sts         i_sts,
    output ebf_pkg::t_ctl         o_ctl,
    output logic                  o_busy
);
    import ebf_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_go;

    assign w_go   = i_start && (r_state == ST_IDLE);
    assign o_busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_go && (i_cmd == CMD_QUERY)) begin
                    n_state = i_sts.query_bad ? ST_RESP : ST_BACK;
                end
            end
            ST_BACK: begin
                if (i_sts.found || i_sts.scan_end) begin
                    n_state = ST_FWD;
                end
            end
            ST_FWD: begin
                if (i_sts.found) begin
                    n_state = i_sts.open_ok ? ST_EMIT : ST_RESP;
                end else if (i_sts.scan_end) begin
                    n_state = i_sts.open_ok ? ST_RESP : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.scan_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ctl = '0;
        case (r_state)
            ST_IDLE: begin
                o_ctl.clear     = w_go && (i_cmd == CMD_CLEAR);
                o_ctl.append    = w_go && (i_cmd == CMD_APPEND);
                o_ctl.load_back = w_go && (i_cmd == CMD_QUERY) && !i_sts.query_bad;
            end
            ST_BACK: begin
                o_ctl.scan     = 1'b1;
                o_ctl.load_fwd = i_sts.found || i_sts.scan_end;
            end
            ST_FWD: begin
                o_ctl.scan       = 1'b1;
                o_ctl.load_emit  = (i_sts.found && i_sts.open_ok)
                                || (i_sts.scan_end && !i_sts.open_ok);
                o_ctl.emit_whole = !i_sts.found;
            end
            ST_EMIT: begin
                o_ctl.scan = 1'b1;
            end
            ST_RESP: begin
                o_ctl.put_empty = 1'b1;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

endmodule

>>> sv/ebf_dpath.sv
// Datapath: text memory, scan pointer, nesting depth and result register.
// Depends on ebf_pkg; commanded by ebf_ctrl.
module ebf_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ebf_pkg::t_ctl               i_ctl,
    input  logic [ebf_pkg::BYTE_W-1:0]  i_text_byte,
    input  logic [ebf_pkg::ADDR_W-1:0]  i_query_position,
    output ebf_pkg::t_sts               o_sts,
    output logic [ebf_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_is_empty,
    output logic                        o_last_byte,
    output logic                        o_strobe
);
    import ebf_pkg::*;

    logic [BYTE_W-1:0] mem [STORE_DEPTH];

    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_pos;
    logic [ADDR_W-1:0] r_ptr;
    logic [LEN_W-1:0]  r_remain;
    logic [LEN_W-1:0]  r_depth;
    t_mode             r_mode;
    logic [ADDR_W-1:0] r_open;
    logic              r_open_ok;

    // read stage
    logic              r_rd_vld;
    logic [BYTE_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] r_rd_idx;
    logic              r_rd_last;

    // result register
    logic              r_o_vld;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_empty;
    logic              r_o_last;

    logic w_load;
    logic w_issue;
    logic w_is_open;
    logic w_is_close;
    logic w_top;
    logic w_found;

    assign w_load     = i_ctl.load_back || i_ctl.load_fwd || i_ctl.load_emit;
    assign w_issue    = i_ctl.scan && !w_load && (r_remain != '0);
    assign w_is_open  = (r_rd_data == CH_OPEN);
    assign w_is_close = (r_rd_data == CH_CLOSE);
    assign w_top      = (r_depth == '0);
    assign w_found    = r_rd_vld && w_top
                     && (((r_mode == MODE_BACK) && w_is_open)
                      || ((r_mode == MODE_FWD) && w_is_close));

    assign o_sts.query_bad = ({1'b0, i_query_position} >= r_len);
    assign o_sts.found     = w_found;
    assign o_sts.scan_end  = (r_remain == '0) && !r_rd_vld;
    assign o_sts.open_ok   = r_open_ok;

    // text memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.append && (r_len < LEN_W'(MAX_TEXT))) begin
            mem[r_len[ADDR_W-1:0]] <= i_text_byte;
        end
        if (w_issue) begin
            r_rd_data <= mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_rd_vld  <= 1'b0;
            r_open_ok <= 1'b0;
            r_mode    <= MODE_BACK;
            r_remain  <= '0;
            r_depth   <= '0;
        end else begin
            if (i_ctl.clear) begin
                r_len <= '0;
            end else if (i_ctl.append && (r_len < LEN_W'(MAX_TEXT))) begin
                r_len <= r_len + LEN_W'(1);
            end

            r_rd_vld <= w_issue;
            if (w_issue) begin
                r_rd_idx  <= r_ptr;
                r_rd_last <= (r_remain == LEN_W'(1));
                r_remain  <= r_remain - LEN_W'(1);
                r_ptr     <= (r_mode == MODE_BACK) ? r_ptr - ADDR_W'(1) : r_ptr + ADDR_W'(1);
            end

            if (w_found && (r_mode == MODE_BACK)) begin
                r_open    <= r_rd_idx;
                r_open_ok <= 1'b1;
            end

            // nesting depth tracks pairs seen so far
            if (r_rd_vld && !w_found) begin
                if (r_mode == MODE_BACK) begin
                    if (w_is_close) begin
                        r_depth <= r_depth + LEN_W'(1);
                    end else if (w_is_open) begin
                        r_depth <= r_depth - LEN_W'(1);
                    end
                end else if (r_mode == MODE_FWD) begin
                    if (w_is_open) begin
                        r_depth <= r_depth + LEN_W'(1);
                    end else if (w_is_close) begin
                        r_depth <= r_depth - LEN_W'(1);
                    end
                end
            end

            // phase loads win over the tail of the previous phase
            if (i_ctl.load_back) begin
                r_pos     <= i_query_position;
                r_ptr     <= i_query_position;
                r_remain  <= {1'b0, i_query_position} + LEN_W'(1);
                r_depth   <= '0;
                r_mode    <= MODE_BACK;
                r_open_ok <= 1'b0;
            end else if (i_ctl.load_fwd) begin
                r_ptr    <= r_pos + ADDR_W'(1);
                r_remain <= r_len - {1'b0, r_pos} - LEN_W'(1);
                r_depth  <= '0;
                r_mode   <= MODE_FWD;
            end else if (i_ctl.load_emit) begin
                r_mode <= MODE_EMIT;
                if (i_ctl.emit_whole) begin
                    r_ptr    <= '0;
                    r_remain <= r_len;
                end else begin
                    r_ptr    <= r_open;
                    r_remain <= {1'b0, r_rd_idx} - {1'b0, r_open} + LEN_W'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= i_ctl.put_empty || (r_rd_vld && (r_mode == MODE_EMIT));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.put_empty) begin
            r_o_byte  <= '0;
            r_o_empty <= 1'b1;
            r_o_last  <= 1'b1;
        end else begin
            r_o_byte  <= r_rd_data;
            r_o_empty <= 1'b0;
            r_o_last  <= r_rd_last;
        end
    end

    assign o_strobe    = r_o_vld;
    assign o_out_byte  = r_o_byte;
    assign o_is_empty  = r_o_empty;
    assign o_last_byte = r_o_last;

endmodule

>>> sv/enclosing_bracket_finder.sv
// Top level of the enclosing bracket finder.
// Depends on ebf_pkg, ebf_ctrl and ebf_dpath.
//
// A request is taken when start is high and busy is low. cmd 0 clears the
// text, cmd 1 appends text_byte (dropped once 64 bytes are held), cmd 3 is
// ignored; these three finish in the cycle they are taken and give no result.
// cmd 2 queries a position: the block walks backward from it (inclusive) for
// the unmatched '(' and forward from the next byte for the unmatched ')', then
// streams the bracketed substring, brackets included, one byte per cycle.
// With neither bracket present the whole text is streamed; with only one, or
// a position at or past the text length, a single result with is_empty set is
// given. Each result is shown on o_out_byte/o_is_empty/o_last_byte for exactly
// one cycle while o_strobe is high; the receiver cannot stall it, so it must
// take every strobe. o_last_byte marks the final result of a query.
// Timing: all three phases go through the single read port of the 64-byte
// text memory, one byte per cycle; each phase also waits on the registered
// read and on seeing its own end. After an in-range query is taken, busy
// stays high through the backward scan, the forward scan and any streamed
// span or whole text, longest for a full buffer streamed whole; a scan that
// hits its bracket is shorter. A streamed last result shows in the last busy
// cycle. An empty result costs one busy cycle after the scans (just that one
// cycle for a position out of range) and shows in the first cycle after busy
// drops, so the next request may be taken in that same cycle.
module enclosing_bracket_finder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [ebf_pkg::CMD_W-1:0]  i_cmd,
    input  logic [ebf_pkg::BYTE_W-1:0] i_text_byte,
    input  logic [ebf_pkg::ADDR_W-1:0] i_query_position,
    output logic                       o_strobe,
    output logic [ebf_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_is_empty,
    output logic                       o_last_byte
);
    import ebf_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    // sequencer
    ebf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    // text store, scanner and result register
    ebf_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .i_text_byte      (i_text_byte),
        .i_query_position (i_query_position),
        .o_sts            (w_sts),
        .o_out_byte       (o_out_byte),
        .o_is_empty       (o_is_empty),
        .o_last_byte      (o_last_byte),
        .o_strobe         (o_strobe)
    );

    // An empty result always closes its query.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_is_empty |-> o_last_byte)
        else $error("empty result without last_byte");

    // An empty result carries a zero byte.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_is_empty |-> (o_out_byte == '0))
        else $error("empty result with nonzero byte");

    // A query keeps the block busy in the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd == CMD_QUERY) |=> busy)
        else $error("query taken but block not busy");

    // Clear, append and unused codes complete at once.
    a_edit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd != CMD_QUERY) |=> !busy)
        else $error("non-query request left block busy");

endmodule

>>> tb/bracket_span_checker.sv
// Result checker for the enclosing bracket finder testbench.
// Depends on ebf_pkg; watches the request and result ports of the block,
// predicts each query's substring and compares every strobed result.
`timescale 1ns / 1ps

module bracket_span_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [ebf_pkg::CMD_W-1:0]  cmd,
    input  logic [ebf_pkg::BYTE_W-1:0] text_byte,
    input  logic [ebf_pkg::ADDR_W-1:0] query_position,
    input  logic                       strobe,
    input  logic [ebf_pkg::BYTE_W-1:0] out_byte,
    input  logic                       is_empty,
    input  logic                       last_byte,
    output int                         fail_count,
    output int                         pending_count
);
    import ebf_pkg::*;

    localparam int NOT_FOUND = -1;

    typedef struct {
        logic [BYTE_W-1:0] byte_val;
        logic              empty;
        logic              last;
    } t_span_byte;

    t_span_byte        spans_due[$];
    logic [BYTE_W-1:0] text_copy [STORE_DEPTH];
    int                text_len;
    int                fail_tally;

    function automatic int find_open(int pos);
        int depth;
        depth = 0;
        for (int i = pos; i >= 0; i--) begin
            if (text_copy[i] == CH_CLOSE) begin
                depth++;
            end else if (text_copy[i] == CH_OPEN) begin
                if (depth == 0) return i;
                depth--;
            end
        end
        return NOT_FOUND;
    endfunction

    function automatic int find_close(int pos);
        int depth;
        depth = 0;
        for (int i = pos + 1; i < text_len; i++) begin
            if (text_copy[i] == CH_OPEN) begin
                depth++;
            end else if (text_copy[i] == CH_CLOSE) begin
                if (depth == 0) return i;
                depth--;
            end
        end
        return NOT_FOUND;
    endfunction

    function automatic void push_span(int first, int final_at);
        t_span_byte item;
        for (int i = first; i <= final_at; i++) begin
            item.byte_val = text_copy[i];
            item.empty    = 1'b0;
            item.last     = (i == final_at);
            spans_due.push_back(item);
        end
    endfunction

    function automatic void push_empty();
        t_span_byte item;
        item.byte_val = '0;
        item.empty    = 1'b1;
        item.last     = 1'b1;
        spans_due.push_back(item);
    endfunction

    function automatic void predict_span(logic [CMD_W-1:0] code, logic [BYTE_W-1:0] ch,
                                         logic [ADDR_W-1:0] pos);
        int open_at;
        int close_at;
        case (code)
            CMD_CLEAR: begin
                text_len = 0;
            end
            CMD_APPEND: begin
                if (text_len < MAX_TEXT) begin
                    text_copy[text_len] = ch;
                    text_len++;
                end
            end
            CMD_QUERY: begin
                if (int'(pos) >= text_len) begin
                    push_empty();
                end else begin
                    open_at  = find_open(int'(pos));
                    close_at = find_close(int'(pos));
                    if (open_at == NOT_FOUND && close_at == NOT_FOUND)
                        push_span(0, text_len - 1);
                    else if (open_at == NOT_FOUND || close_at == NOT_FOUND)
                        push_empty();
                    else
                        push_span(open_at, close_at);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_span_byte want;
        if (!i_rst_n) begin
            spans_due.delete();
            text_len   = 0;
            fail_tally = 0;
        end else begin
            // results first: a result in the cycle busy drops belongs to the old query
            if (strobe) begin
                if (spans_due.size() == 0) begin
                    $error("unexpected result: out_byte %h is_empty %b last_byte %b",
                           out_byte, is_empty, last_byte);
                    fail_tally++;
                end else begin
                    want = spans_due.pop_front();
                    if (out_byte !== want.byte_val) begin
                        $error("out_byte mismatch: expected %h, got %h",
                               want.byte_val, out_byte);
                        fail_tally++;
                    end
                    if (is_empty !== want.empty) begin
                        $error("is_empty mismatch: expected %b, got %b", want.empty, is_empty);
                        fail_tally++;
                    end
                    if (last_byte !== want.last) begin
                        $error("last_byte mismatch: expected %b, got %b", want.last, last_byte);
                        fail_tally++;
                    end
                end
            end
            if (start && !busy)
                predict_span(cmd, text_byte, query_position);
        end
        fail_count    <= fail_tally;
        pending_count <= spans_due.size();
    end

endmodule

>>> tb/enclosing_bracket_finder_test.sv
// Top of the enclosing bracket finder testbench: clock, reset, request stimulus.
// Depends on ebf_pkg, enclosing_bracket_finder and bracket_span_checker.
`timescale 1ns / 1ps

module enclosing_bracket_finder_test;
    import ebf_pkg::*;

    // cmd 3 has no name in the package; the block ignores it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // even full-buffer queries with idle gaps between requests, over the
    // ~400 requests of the worst case, stay far below this
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 250;
    localparam int RANDOM_ITEMS = 310;

    logic                i_clk;
    logic                i_rst_n          = 1'b0;
    logic                start            = 1'b0;
    logic [CMD_W-1:0]    i_cmd            = CMD_CLEAR;
    logic [BYTE_W-1:0]   i_text_byte      = '0;
    logic [ADDR_W-1:0]   i_query_position = '0;
    logic                busy;
    logic                o_strobe;
    logic [BYTE_W-1:0]   o_out_byte;
    logic                o_is_empty;
    logic                o_last_byte;

    int fail_count;
    int pending_count;
    int cycle_count;
    int items_sent;
    int idle_pct;

    enclosing_bracket_finder uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_text_byte      (i_text_byte),
        .i_query_position (i_query_position),
        .o_strobe         (o_strobe),
        .o_out_byte       (o_out_byte),
        .o_is_empty       (o_is_empty),
        .o_last_byte      (o_last_byte)
    );

    // Prediction and comparison live in the checker; it only reports back.
    bracket_span_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (i_cmd),
        .text_byte      (i_text_byte),
        .query_position (i_query_position),
        .strobe         (o_strobe),
        .out_byte       (o_out_byte),
        .is_empty       (o_is_empty),
        .last_byte      (o_last_byte),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("enclosing_bracket_finder_test: FAIL");
        $finish;
    end

    // One request. Called right after a rising edge; returns right after the
    // edge that took it. start stays high between back-to-back requests, so
    // there is only one assignment to it per time step.
    task automatic issue_request(input logic [CMD_W-1:0] code, input logic [BYTE_W-1:0] ch,
                                 input logic [ADDR_W-1:0] pos);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_cmd            <= code;
        i_text_byte      <= ch;
        i_query_position <= pos;
        // busy read here is its value before the edge: taken when it was low
        do @(posedge i_clk); while (busy);
        if (code != CMD_UNUSED) items_sent++;
    endtask

    // Bracket-heavy text: mostly nested pairs, some stray closers, some filler.
    // Filler is sometimes a fully random byte so every data bit toggles.
    function automatic logic [BYTE_W-1:0] pick_char(ref int depth);
        int roll;
        roll = $urandom_range(99);
        if (roll < 35) begin
            depth++;
            return CH_OPEN;
        end
        if (roll < 65 && depth > 0) begin
            depth--;
            return CH_CLOSE;
        end
        if (roll < 70) return CH_CLOSE;
        if (roll < 90) return BYTE_W'($urandom_range(8'h61, 8'h7a));
        return BYTE_W'($urandom_range(255));
    endfunction

    // Clear, load a text, then a few queries with some noise mixed in.
    // A small share of texts fill the buffer and push appends past the end.
    task automatic run_text_block(input bit fill_all);
        int n;
        int len;
        int depth;
        int roll;
        int queries;
        depth = 0;
        issue_request(CMD_CLEAR, BYTE_W'($urandom_range(255)), ADDR_W'($urandom_range(63)));
        if (fill_all || $urandom_range(7) == 0)
            n = MAX_TEXT + $urandom_range(0, 3);
        else
            n = $urandom_range(1, 16);
        for (int k = 0; k < n; k++)
            issue_request(CMD_APPEND, pick_char(depth), ADDR_W'($urandom_range(63)));
        len     = (n > MAX_TEXT) ? MAX_TEXT : n;
        queries = $urandom_range(2, 5);
        for (int q = 0; q < queries; q++) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
                issue_request(CMD_UNUSED, BYTE_W'($urandom_range(255)),
                              ADDR_W'($urandom_range(63)));
            end else if (roll < 12) begin
                // append between queries
                issue_request(CMD_APPEND, pick_char(depth), ADDR_W'($urandom_range(63)));
                if (len < MAX_TEXT) len++;
            end else if (roll < 26) begin
                // any position, often past the text end
                issue_request(CMD_QUERY, BYTE_W'($urandom_range(255)),
                              ADDR_W'($urandom_range(63)));
            end else begin
                issue_request(CMD_QUERY, BYTE_W'($urandom_range(255)),
                              ADDR_W'($urandom_range(0, len - 1)));
            end
        end
    endtask

    initial begin
        int phase_idle[4];
        phase_idle = '{0, 73, 0, 17};
        items_sent = 0;
        idle_pct   = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // query on empty text: out of range
        issue_request(CMD_QUERY, 8'h00, 6'd0);
        // "(a)"
        issue_request(CMD_APPEND, CH_OPEN, 6'd0);
        issue_request(CMD_APPEND, "a", 6'd0);
        issue_request(CMD_APPEND, CH_CLOSE, 6'd0);
        issue_request(CMD_QUERY, 8'h00, 6'd1);    // inside the pair
        issue_request(CMD_QUERY, 8'hff, 6'd0);    // on the '(' itself
        issue_request(CMD_QUERY, 8'h00, 6'd2);    // on the ')': counted as nested, whole text
        issue_request(CMD_QUERY, 8'h00, 6'd3);    // just past the end
        issue_request(CMD_QUERY, 8'h00, 6'd63);   // far past the end
        // "(a)x(" : opener only at the tail
        issue_request(CMD_APPEND, "x", 6'd0);
        issue_request(CMD_APPEND, CH_OPEN, 6'd0);
        issue_request(CMD_QUERY, 8'h00, 6'd4);    // only one bracket
        issue_request(CMD_QUERY, 8'h00, 6'd3);    // between pairs: neither
        issue_request(CMD_UNUSED, 8'hff, 6'd63);  // ignored
        issue_request(CMD_QUERY, 8'h00, 6'd1);    // still "(a)" after the ignored one
        // clear, then extreme bytes with no brackets
        issue_request(CMD_CLEAR, 8'hff, 6'd63);
        issue_request(CMD_QUERY, 8'h00, 6'd0);
        issue_request(CMD_APPEND, 8'hff, 6'd63);
        issue_request(CMD_APPEND, 8'h00, 6'd0);
        issue_request(CMD_QUERY, 8'h00, 6'd0);
        issue_request(CMD_QUERY, 8'h00, 6'd1);
        // ")" : the lone closer is seen only backward, so the whole text streams
        issue_request(CMD_CLEAR, 8'h00, 6'd0);
        issue_request(CMD_APPEND, CH_CLOSE, 6'd0);
        issue_request(CMD_QUERY, 8'h00, 6'd0);

        // ---- random part, four idling phases ----
        // first block always fills the buffer and may overflow it
        run_text_block(1'b1);
        while (items_sent < RANDOM_ITEMS) begin
            idle_pct = phase_idle[(items_sent * 4) / RANDOM_ITEMS];
            run_text_block(1'b0);
        end
        start <= 1'b0;

        // wait out every expected result, then let the block settle
        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0)
            $display("enclosing_bracket_finder_test: PASS");
        else
            $display("enclosing_bracket_finder_test: FAIL");
        $finish;
    end

endmodule
